### rtl/sptcr_pkg.sv
// Package: shared types, constants and elaboration-time helpers for the circle snap block.
`timescale 1ns / 1ps
package sptcr_pkg;

  localparam int CoordW         = 32;
  localparam int RegW           = 31;
  localparam int CfgIdxW        = 2;
  localparam int GuardBits      = 16;
  localparam int VecW           = 51;
  localparam int CordicMax      = 32;
  localparam int QueueDepth     = 2;
  localparam int CoordWidthDef  = 32;
  localparam int CordicStagesDef = 24;

  typedef enum logic [1:0] {
    STATUS_PASS    = 2'd0,
    STATUS_INNER   = 2'd1,
    STATUS_OUTER   = 2'd2,
    STATUS_NOMATCH = 2'd3
  } snap_status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INNER_RADIUS    = 2'd0,
    CFG_OUTER_RADIUS    = 2'd1,
    CFG_MATCH_TOLERANCE = 2'd2
  } cfg_index_e;

  typedef struct packed {
    logic                     is_curved;
    logic signed [CoordW-1:0] x_in;
    logic signed [CoordW-1:0] y_in;
  } req_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x_out;
    logic signed [CoordW-1:0] y_out;
    snap_status_e             snap_status;
  } rsp_t;

  typedef struct packed {
    logic [RegW-1:0] inner_radius;
    logic [RegW-1:0] outer_radius;
    logic [RegW-1:0] match_tolerance;
  } cfg_t;

  // Classified node handed from the front to the back.
  typedef struct packed {
    snap_status_e             status;
    logic [RegW-1:0]          radius;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef struct packed {
    snap_status_e             status;
    logic                     flip;
    logic                     origin;
    logic [RegW-1:0]          radius;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CordicMax-1:0]     dir;
  } back_meta_t;

  function automatic logic [63:0] isqrt_c(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] nn;
    res  = '0;
    bitv = 64'd1 << 62;
    nn   = n;
    for (int i = 0; i < 32; i++) begin
      if (nn >= res + bitv) begin
        nn  = nn - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Inverse CORDIC gain in Q30, rounded; long division by shift and subtract.
  function automatic logic [63:0] gain_inv_q30(int stages);
    logic [63:0] p;
    logic [63:0] k;
    logic [63:0] num;
    logic [63:0] q;
    logic [64:0] rem;
    p = 64'd1 << 60;
    for (int i = 0; i < stages; i++) begin
      p = p + (p >> (2 * i));
    end
    k = isqrt_c(p);
    if (k == 64'd0) begin
      k = 64'd1;
    end
    num = (64'd1 << 60) + (k >> 1);
    q   = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, k}) begin
        rem  = rem - {1'b0, k};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

### rtl/sptcr_front.sv
// Front: input capture, squared radius, pipelined square root and radius match.
`timescale 1ns / 1ps
module sptcr_front #(
  parameter int COORD_WIDTH = sptcr_pkg::CoordWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  sptcr_pkg::req_t   req_i,
  input  sptcr_pkg::cfg_t   cfg_i,
  output logic              valid_o,
  output sptcr_pkg::job_t   job_o
);

  localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int SW = 2 * CW;
  localparam int DW = 33;

  logic                                 v0_q, c0_q;
  logic signed [sptcr_pkg::CoordW-1:0]  x0_q, y0_q;
  logic signed [sptcr_pkg::CoordW-1:0]  x0_d, y0_d;
  logic signed [CW-1:0]                 xs, ys;

  logic                                 v1_q, c1_q;
  logic signed [sptcr_pkg::CoordW-1:0]  x1_q, y1_q;
  logic [SW-1:0]                        sqx_q, sqy_q;
  logic [sptcr_pkg::CoordW-1:0]         ax32, ay32;
  logic [CW-1:0]                        ax, ay;

  logic                                 vi_q [0:CW];
  logic                                 ci_q [0:CW];
  logic signed [sptcr_pkg::CoordW-1:0]  xi_q [0:CW];
  logic signed [sptcr_pkg::CoordW-1:0]  yi_q [0:CW];
  logic [SW-1:0]                        n_q  [0:CW];
  logic [SW-1:0]                        res_q[0:CW];
  logic [SW-1:0]                        n_d  [0:CW-1];
  logic [SW-1:0]                        res_d[0:CW-1];
  logic [SW-1:0]                        trial[0:CW-1];

  logic [DW-1:0]                        r_rnd, rad_in, rad_out, d_in, d_out, tol;
  sptcr_pkg::job_t                      job_d, job_q;
  logic                                 job_vld_q;

  assign xs   = req_i.x_in[CW-1:0];
  assign ys   = req_i.y_in[CW-1:0];
  assign x0_d = sptcr_pkg::CoordW'(xs);
  assign y0_d = sptcr_pkg::CoordW'(ys);

  assign ax32 = x0_q[sptcr_pkg::CoordW-1] ? sptcr_pkg::CoordW'(-x0_q) : sptcr_pkg::CoordW'(x0_q);
  assign ay32 = y0_q[sptcr_pkg::CoordW-1] ? sptcr_pkg::CoordW'(-y0_q) : sptcr_pkg::CoordW'(y0_q);
  assign ax   = ax32[CW-1:0];
  assign ay   = ay32[CW-1:0];

  // One restoring square-root step per stage.
  always_comb begin
    for (int k = 0; k < CW; k++) begin
      trial[k] = res_q[k] + (SW'(1) << (SW - 2 - 2 * k));
      if (n_q[k] >= trial[k]) begin
        n_d[k]   = n_q[k] - trial[k];
        res_d[k] = (res_q[k] >> 1) + (SW'(1) << (SW - 2 - 2 * k));
      end else begin
        n_d[k]   = n_q[k];
        res_d[k] = res_q[k] >> 1;
      end
    end
  end

  // Round to nearest, then check inner before outer.
  always_comb begin
    r_rnd   = DW'(res_q[CW][CW-1:0]) + DW'(n_q[CW] > res_q[CW]);
    rad_in  = DW'(cfg_i.inner_radius);
    rad_out = DW'(cfg_i.outer_radius);
    tol     = DW'(cfg_i.match_tolerance);
    d_in    = (r_rnd > rad_in) ? r_rnd - rad_in : rad_in - r_rnd;
    d_out   = (r_rnd > rad_out) ? r_rnd - rad_out : rad_out - r_rnd;
    job_d.x = xi_q[CW];
    job_d.y = yi_q[CW];
    job_d.radius = cfg_i.inner_radius;
    if (!ci_q[CW]) begin
      job_d.status = sptcr_pkg::STATUS_PASS;
    end else if (d_in < tol) begin
      job_d.status = sptcr_pkg::STATUS_INNER;
    end else if (d_out < tol) begin
      job_d.status = sptcr_pkg::STATUS_OUTER;
      job_d.radius = cfg_i.outer_radius;
    end else begin
      job_d.status = sptcr_pkg::STATUS_NOMATCH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q      <= 1'b0;
      v1_q      <= 1'b0;
      job_vld_q <= 1'b0;
      for (int k = 0; k <= CW; k++) begin
        vi_q[k] <= 1'b0;
      end
    end else begin
      v0_q      <= valid_i;
      v1_q      <= v0_q;
      vi_q[0]   <= v1_q;
      for (int k = 0; k < CW; k++) begin
        vi_q[k+1] <= vi_q[k];
      end
      job_vld_q <= vi_q[CW];
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q     <= req_i.is_curved;
    x0_q     <= x0_d;
    y0_q     <= y0_d;
    c1_q     <= c0_q;
    x1_q     <= x0_q;
    y1_q     <= y0_q;
    sqx_q    <= SW'(ax) * SW'(ax);
    sqy_q    <= SW'(ay) * SW'(ay);
    ci_q[0]  <= c1_q;
    xi_q[0]  <= x1_q;
    yi_q[0]  <= y1_q;
    n_q[0]   <= sqx_q + sqy_q;
    res_q[0] <= '0;
    for (int k = 0; k < CW; k++) begin
      ci_q[k+1]  <= ci_q[k];
      xi_q[k+1]  <= xi_q[k];
      yi_q[k+1]  <= yi_q[k];
      n_q[k+1]   <= n_d[k];
      res_q[k+1] <= res_d[k];
    end
    job_q <= job_d;
  end

  assign valid_o = job_vld_q;
  assign job_o   = job_q;

endmodule

### rtl/sptcr_queue.sv
// Queue: short FIFO between the classifying front and the CORDIC back.
`timescale 1ns / 1ps
module sptcr_queue (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  sptcr_pkg::job_t          job_i,
  input  logic                     pop_i,
  output sptcr_pkg::job_t          job_o,
  output sptcr_pkg::queue_status_t status_o
);

  localparam int PtrW = (sptcr_pkg::QueueDepth > 1) ? $clog2(sptcr_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(sptcr_pkg::QueueDepth + 1);

  sptcr_pkg::job_t  mem_q [0:sptcr_pkg::QueueDepth-1];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == CntW'(sptcr_pkg::QueueDepth));
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(sptcr_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(sptcr_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

### rtl/sptcr_back.sv
// Back: gain scaling, CORDIC vectoring and rotation stages, rounding and saturation.
`timescale 1ns / 1ps
module sptcr_back #(
  parameter int COORD_WIDTH   = sptcr_pkg::CoordWidthDef,
  parameter int CORDIC_STAGES = sptcr_pkg::CordicStagesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  sptcr_pkg::job_t  job_i,
  output logic             valid_o,
  output sptcr_pkg::rsp_t  rsp_o
);

  localparam int CW = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int N  = CORDIC_STAGES;
  localparam int VW = sptcr_pkg::VecW;
  localparam int PW = 61;
  localparam logic [63:0] KinvFull = sptcr_pkg::gain_inv_q30(CORDIC_STAGES);
  localparam logic [29:0] Kinv     = KinvFull[29:0];
  localparam logic signed [VW-1:0] SatHi     = VW'((64'd1 << (CW - 1)) - 64'd1);
  localparam logic signed [VW-1:0] SatLo     = -SatHi - VW'(1);
  localparam logic signed [VW-1:0] RoundHalf = VW'(64'd1 << (sptcr_pkg::GuardBits - 1));

  function automatic logic signed [sptcr_pkg::CoordW-1:0] sat(logic signed [VW-1:0] v);
    logic signed [VW-1:0] s;
    s = (v > SatHi) ? SatHi : ((v < SatLo) ? SatLo : v);
    return sptcr_pkg::CoordW'(s);
  endfunction

  logic                  vld_q [0:2*N];
  sptcr_pkg::back_meta_t m_q   [0:2*N];
  sptcr_pkg::back_meta_t m_d   [0:2*N-1];
  logic signed [VW-1:0]  vx_q  [0:N];
  logic signed [VW-1:0]  vy_q  [0:N];
  logic signed [VW-1:0]  vx_d  [0:N-1];
  logic signed [VW-1:0]  vy_d  [0:N-1];
  logic signed [VW-1:0]  x0_q  [0:N];
  logic signed [VW-1:0]  rx_q  [0:N-1];
  logic signed [VW-1:0]  ry_q  [0:N-1];
  logic signed [VW-1:0]  rxi   [0:N-1];
  logic signed [VW-1:0]  ryi   [0:N-1];
  logic signed [VW-1:0]  rx_d  [0:N-1];
  logic signed [VW-1:0]  ry_d  [0:N-1];

  sptcr_pkg::back_meta_t m0_d;
  logic signed [VW-1:0]  xe, ye, vx0_d, vy0_d, x0_d;
  logic [PW-1:0]         prod, x0u;

  logic signed [VW-1:0]  fx_r, fy_r, fx_s, fy_s, fx_n, fy_n, rad_v;
  sptcr_pkg::back_meta_t mf;
  sptcr_pkg::rsp_t       rsp_d, rsp_q;
  logic                  out_vld_q;

  // Entry: fold the node into the right half plane and scale the radius by 1/K.
  always_comb begin
    xe          = VW'(job_i.x);
    ye          = VW'(job_i.y);
    m0_d.status = job_i.status;
    m0_d.flip   = job_i.x[sptcr_pkg::CoordW-1];
    m0_d.origin = (job_i.x == '0) && (job_i.y == '0);
    m0_d.radius = job_i.radius;
    m0_d.x      = job_i.x;
    m0_d.y      = job_i.y;
    m0_d.dir    = '0;
    vx0_d       = (m0_d.flip ? -xe : xe) <<< sptcr_pkg::GuardBits;
    vy0_d       = (m0_d.flip ? -ye : ye) <<< sptcr_pkg::GuardBits;
    prod        = PW'(job_i.radius) * PW'(Kinv);
    x0u         = (prod + PW'(8192)) >> 14;
    x0_d        = $signed(VW'(x0u));
  end

  // Vectoring: drive y to zero, record each direction.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      m_d[k] = m_q[k];
      m_d[k].dir[k] = !vy_q[k][VW-1];
      if (!vy_q[k][VW-1]) begin
        vx_d[k] = vx_q[k] + (vy_q[k] >>> k);
        vy_d[k] = vy_q[k] - (vx_q[k] >>> k);
      end else begin
        vx_d[k] = vx_q[k] - (vy_q[k] >>> k);
        vy_d[k] = vy_q[k] + (vx_q[k] >>> k);
      end
    end
  end

  // Rotation: replay the directions in reverse sense from (R/K, 0).
  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        rxi[k] = x0_q[N];
        ryi[k] = '0;
      end else begin
        rxi[k] = rx_q[k-1];
        ryi[k] = ry_q[k-1];
      end
      m_d[N+k] = m_q[N+k];
      if (m_q[N+k].dir[k]) begin
        rx_d[k] = rxi[k] - (ryi[k] >>> k);
        ry_d[k] = ryi[k] + (rxi[k] >>> k);
      end else begin
        rx_d[k] = rxi[k] + (ryi[k] >>> k);
        ry_d[k] = ryi[k] - (rxi[k] >>> k);
      end
    end
  end

  // Exit: round from Q34.16 to integer, unfold, saturate, pick the result.
  always_comb begin
    mf    = m_q[2*N];
    fx_r  = rx_q[N-1] + RoundHalf;
    fy_r  = ry_q[N-1] + RoundHalf;
    fx_s  = fx_r >>> sptcr_pkg::GuardBits;
    fy_s  = fy_r >>> sptcr_pkg::GuardBits;
    fx_n  = mf.flip ? -fx_s : fx_s;
    fy_n  = mf.flip ? -fy_s : fy_s;
    rad_v = VW'(mf.radius);
    rsp_d.snap_status = mf.status;
    unique case (mf.status)
      sptcr_pkg::STATUS_PASS, sptcr_pkg::STATUS_NOMATCH: begin
        rsp_d.x_out = mf.x;
        rsp_d.y_out = mf.y;
      end
      sptcr_pkg::STATUS_INNER, sptcr_pkg::STATUS_OUTER: begin
        if (mf.origin) begin
          rsp_d.x_out = sat(rad_v);
          rsp_d.y_out = '0;
        end else begin
          rsp_d.x_out = sat(fx_n);
          rsp_d.y_out = sat(fy_n);
        end
      end
      default: begin
        rsp_d.x_out = mf.x;
        rsp_d.y_out = mf.y;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= 2 * N; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
      for (int k = 0; k < 2 * N; k++) begin
        vld_q[k+1] <= vld_q[k];
      end
      out_vld_q <= vld_q[2*N];
    end
  end

  always_ff @(posedge clk_i) begin
    m_q[0]  <= m0_d;
    vx_q[0] <= vx0_d;
    vy_q[0] <= vy0_d;
    x0_q[0] <= x0_d;
    for (int k = 0; k < N; k++) begin
      m_q[k+1]  <= m_d[k];
      vx_q[k+1] <= vx_d[k];
      vy_q[k+1] <= vy_d[k];
      x0_q[k+1] <= x0_q[k];
      m_q[N+k+1] <= m_d[N+k];
      rx_q[k]   <= rx_d[k];
      ry_q[k]   <= ry_d[k];
    end
    rsp_q <= rsp_d;
  end

  assign valid_o = out_vld_q;
  assign rsp_o   = rsp_q;

endmodule

### rtl/snap_point_to_circle_radius.sv
// Top level: snaps curved mesh nodes onto the inner or outer circle radius.
`timescale 1ns / 1ps
// Throughput: one request per cycle; the square root and both CORDIC passes are fully
//   pipelined, one step per stage, so busy stays low in steady streaming.
// Results cannot be stalled: each shows on rsp_o for one cycle with rsp_valid_o.
// Reset (rst_ni low, asynchronous) clears all valid flags and the queue and loads the
//   radius and tolerance registers with their defaults.
module snap_point_to_circle_radius #(
  parameter int COORD_WIDTH   = sptcr_pkg::CoordWidthDef,
  parameter int CORDIC_STAGES = sptcr_pkg::CordicStagesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  sptcr_pkg::req_t                   req_i,
  output logic                              rsp_valid_o,
  output sptcr_pkg::rsp_t                   rsp_o,
  input  logic                              cfg_we_i,
  input  logic [sptcr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [sptcr_pkg::RegW-1:0]        cfg_data_i
);

  localparam int CW      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int LATENCY = 7 + CW + 2 * CORDIC_STAGES;

  sptcr_pkg::cfg_t          cfg_q;
  sptcr_pkg::job_t          front_job, queue_job;
  sptcr_pkg::queue_status_t q_status;
  logic                     accept, front_vld, pop;

  // Configuration writes land directly; software must write only while idle, as the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inner_radius    <= sptcr_pkg::RegW'(65536);
      cfg_q.outer_radius    <= sptcr_pkg::RegW'(131072);
      cfg_q.match_tolerance <= sptcr_pkg::RegW'(7);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sptcr_pkg::CFG_INNER_RADIUS:    cfg_q.inner_radius    <= cfg_data_i;
        sptcr_pkg::CFG_OUTER_RADIUS:    cfg_q.outer_radius    <= cfg_data_i;
        sptcr_pkg::CFG_MATCH_TOLERANCE: cfg_q.match_tolerance <= cfg_data_i;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Hold off new requests only if the queue ever fills.
  assign busy   = q_status.full;
  assign accept = start && !busy;

  sptcr_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .cfg_i   (cfg_q),
    .valid_o (front_vld),
    .job_o   (front_job)
  );

  // Advance the back whenever the queue holds a classified node.
  assign pop = !q_status.empty;

  sptcr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_vld),
    .job_i    (front_job),
    .pop_i    (pop),
    .job_o    (queue_job),
    .status_o (q_status)
  );

  sptcr_back #(
    .COORD_WIDTH   (COORD_WIDTH),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pop),
    .job_i   (queue_job),
    .valid_o (rsp_valid_o),
    .rsp_o   (rsp_o)
  );

endmodule

### rtl/sptcr_checker.sv
// Checker: port-level timing and status checks, bound to the top level.
`timescale 1ns / 1ps
module sptcr_checker #(
  parameter int Latency = 87
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input sptcr_pkg::req_t req_i,
  input logic            rsp_valid_o,
  input sptcr_pkg::rsp_t rsp_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised: queue filled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency rsp_valid_o)
    else $error("missing result for accepted request");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !rsp_valid_o)
    else $error("result without request");

  a_pass_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !req_i.is_curved) |->
      ##Latency (rsp_o.snap_status == sptcr_pkg::STATUS_PASS))
    else $error("uncurved node not passed");

  a_curved_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && req_i.is_curved) |->
      ##Latency (rsp_o.snap_status != sptcr_pkg::STATUS_PASS))
    else $error("curved node reported as passed");

endmodule

bind snap_point_to_circle_radius sptcr_checker #(.Latency(LATENCY)) u_sptcr_checker (.*);

### tb/snap_checker.sv
// Checker: watches the request, result and register ports, predicts each result and compares.
`timescale 1ns / 1ps
module snap_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          busy,
  input  sptcr_pkg::req_t               req_i,
  input  logic                          rsp_valid_o,
  input  sptcr_pkg::rsp_t               rsp_o,
  input  logic                          cfg_we_i,
  input  logic [sptcr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sptcr_pkg::RegW-1:0]    cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import sptcr_pkg::*;

  localparam int Stages = 24;

  logic [RegW-1:0] inner_r, outer_r, tol_r;
  rsp_t            snapped_q[$];
  logic [63:0]     kinv;
  int              fails;
  int              depth;

  assign fail_count_o = fails;
  assign pending_o    = depth;

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] t;
    res = '0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= n) res = t;
    end
    return res;
  endfunction

  function automatic logic [63:0] sra(logic [63:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [31:0] clip(logic [63:0] v);
    if (v[63] && (64'd0 - v) > 64'h8000_0000) return 32'h8000_0000;
    if (!v[63] && v > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return v[31:0];
  endfunction

  // Turn the node onto the circle of radius rad, keeping its angle.
  task automatic to_circle(input logic [63:0] xi, input logic [63:0] yi,
                           input logic [63:0] rad, output logic [63:0] ox,
                           output logic [63:0] oy);
    logic [Stages-1:0] cw;
    logic              flip;
    logic [63:0]       vx, vy, nx, px, py;
    flip = xi[63];
    if (xi == 0 && yi == 0) begin
      ox = rad;
      oy = 0;
      return;
    end
    if (flip) begin
      xi = 64'd0 - xi;
      yi = 64'd0 - yi;
    end
    vx = xi << 16;
    vy = yi << 16;
    for (int i = 0; i < Stages; i++) begin
      cw[i] = !vy[63];
      if (cw[i]) begin
        nx = vx + sra(vy, i);
        vy = vy - sra(vx, i);
      end else begin
        nx = vx - sra(vy, i);
        vy = vy + sra(vx, i);
      end
      vx = nx;
    end
    px = (rad * kinv + (64'd1 << 13)) >> 14;
    py = 0;
    for (int i = 0; i < Stages; i++) begin
      if (cw[i]) begin
        nx = px - sra(py, i);
        py = py + sra(px, i);
      end else begin
        nx = px + sra(py, i);
        py = py - sra(px, i);
      end
      px = nx;
    end
    px = sra(px + (64'd1 << 15), 16);
    py = sra(py + (64'd1 << 15), 16);
    if (flip) begin
      px = 64'd0 - px;
      py = 64'd0 - py;
    end
    ox = px;
    oy = py;
  endtask

  task automatic predict(input req_t rq, output rsp_t o);
    logic [63:0] x, y, ax, ay, sq, r, d, ox, oy;
    x = {{32{rq.x_in[31]}}, rq.x_in};
    y = {{32{rq.y_in[31]}}, rq.y_in};
    o.x_out       = rq.x_in;
    o.y_out       = rq.y_in;
    o.snap_status = STATUS_PASS;
    if (!rq.is_curved) return;
    ax = x[63] ? 64'd0 - x : x;
    ay = y[63] ? 64'd0 - y : y;
    sq = ax * ax + ay * ay;
    r  = root64(sq);
    if (sq - r * r > r) r++;
    ox = x;
    oy = y;
    d  = (r > inner_r) ? r - inner_r : inner_r - r;
    if (d < tol_r) begin
      o.snap_status = STATUS_INNER;
      to_circle(x, y, inner_r, ox, oy);
    end else begin
      d = (r > outer_r) ? r - outer_r : outer_r - r;
      if (d < tol_r) begin
        o.snap_status = STATUS_OUTER;
        to_circle(x, y, outer_r, ox, oy);
      end else begin
        o.snap_status = STATUS_NOMATCH;
      end
    end
    o.x_out = clip(ox);
    o.y_out = clip(oy);
  endtask

  initial begin
    logic [63:0] p, k;
    p = 64'd1 << 60;
    for (int i = 0; i < Stages; i++) p = p + (p >> (2 * i));
    k = root64(p);
    if (k == 0) k = 1;
    kinv  = ((64'd1 << 60) + k / 2) / k;
    fails = 0;
    depth = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want, got_pred;
    if (!rst_ni) begin
      inner_r <= 31'd65536;
      outer_r <= 31'd131072;
      tol_r   <= 31'd7;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_INNER_RADIUS:    inner_r <= cfg_data_i;
          CFG_OUTER_RADIUS:    outer_r <= cfg_data_i;
          CFG_MATCH_TOLERANCE: tol_r   <= cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_valid_o) begin
        if (snapped_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result x=%h y=%h st=%0d",
                                    rsp_o.x_out, rsp_o.y_out, rsp_o.snap_status);
        end else begin
          want = snapped_q.pop_front();
          if (rsp_o.x_out !== want.x_out || rsp_o.y_out !== want.y_out ||
              rsp_o.snap_status !== want.snap_status) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: exp x=%h y=%h st=%0d  got x=%h y=%h st=%0d",
                       want.x_out, want.y_out, want.snap_status,
                       rsp_o.x_out, rsp_o.y_out, rsp_o.snap_status);
          end
        end
      end
      if (start && !busy) begin
        predict(req_i, got_pred);
        snapped_q.push_back(got_pred);
      end
      depth = snapped_q.size();
    end
  end
endmodule

### tb/tb_snap_point_to_circle_radius.sv
// Testbench top: drives node requests and register writes, reports the verdict.
`timescale 1ns / 1ps
module tb_snap_point_to_circle_radius;
  import sptcr_pkg::*;

  localparam int Latency = 87;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  req_t            req_i = '0;
  logic            rsp_valid_o;
  rsp_t            rsp_o;
  logic            cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CFG_INNER_RADIUS;
  logic [RegW-1:0] cfg_data_i = '0;
  int              fail_count, pending;

  // Current register values, kept here so stimulus can aim at the circles.
  logic [RegW-1:0] cur_inner = 31'd65536, cur_outer = 31'd131072, cur_tol = 31'd7;
  int              idle_pct = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  snap_point_to_circle_radius i_dut (.*);

  snap_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .req_i, .rsp_valid_o, .rsp_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #(12ns * 400000);
    $display("Verification failed");
    $finish;
  end

  // Drive one request; inputs change on the falling edge, hold until accepted.
  task automatic send(input logic curved, input logic [31:0] x, input logic [31:0] y);
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    start         = 1'b1;
    req_i.is_curved = curved;
    req_i.x_in    = x;
    req_i.y_in    = y;
    #1;
    while (busy) begin
      @(negedge clk_i);
      #1;
    end
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Write one register; only called while nothing is in flight.
  task automatic write_reg(input cfg_index_e idx, input logic [RegW-1:0] val);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_INNER_RADIUS:    cur_inner = val;
      CFG_OUTER_RADIUS:    cur_outer = val;
      default:             cur_tol   = val;
    endcase
  endtask

  // Drain the pipe, then hold for the latency so the block is really idle.
  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
  endtask

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Send a curved node close to the circle of radius rad, jittered around the tolerance.
  task automatic near_circle(input logic [RegW-1:0] rad);
    longint xm, ym, j, span;
    xm   = $urandom_range(0, rad);
    ym   = longint'($sqrt(real'(rad) * real'(rad) - real'(xm) * real'(xm)));
    span = (cur_tol > 64) ? 64 : cur_tol + 2;
    j    = longint'($urandom_range(0, 2 * span)) - span;
    if ($urandom_range(1)) xm = -xm;
    if ($urandom_range(1)) ym = -ym;
    if ($urandom_range(1)) send(1'b1, clamp32(xm + j), clamp32(ym));
    else                   send(1'b1, clamp32(ym), clamp32(xm + j));
  endtask

  task automatic random_items(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)      near_circle(cur_inner);
      else if (pick < 70) near_circle(cur_outer);
      else if (pick < 85) send(1'b1, $urandom, $urandom);
      else if (pick < 87) send(1'b1, 32'd0, 32'd0);
      else                send(1'b0, $urandom, $urandom);
    end
  endtask

  // Directed corners: extremes, origin, the +x, -x and -y axes, flipped half plane.
  task automatic corners();
    send(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
    send(1'b0, 32'h8000_0000, 32'h7FFF_FFFF);
    send(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
    send(1'b1, 32'h8000_0000, 32'h8000_0000);
    send(1'b1, 32'd0, 32'd0);
    send(1'b1, cur_inner, 32'd0);
    send(1'b1, -cur_inner, 32'd0);
    send(1'b1, 32'd0, -cur_outer);
    send(1'b1, -cur_outer, 32'd1);
    send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  initial begin
    int idle_set[5] = '{0, 61, 0, 22, 61};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Phase: reset defaults.
    idle_pct = idle_set[0];
    corners();
    random_items(150);
    drain();

    // Phase: zero inner, widest outer and tolerance; every curved node snaps to a circle.
    write_reg(CFG_INNER_RADIUS, '0);
    write_reg(CFG_OUTER_RADIUS, 31'h7FFF_FFFF);
    write_reg(CFG_MATCH_TOLERANCE, 31'h7FFF_FFFF);
    idle_pct = idle_set[1];
    corners();
    random_items(150);
    drain();

    // Phase: zero tolerance never matches.
    write_reg(CFG_MATCH_TOLERANCE, '0);
    write_reg(CFG_INNER_RADIUS, 31'd65536);
    idle_pct = idle_set[2];
    random_items(120);
    drain();

    // Phase: random moderate radii and tolerance.
    write_reg(CFG_INNER_RADIUS, $urandom_range(1, 1 << 22));
    write_reg(CFG_OUTER_RADIUS, cur_inner + $urandom_range(1, 1 << 22));
    write_reg(CFG_MATCH_TOLERANCE, $urandom_range(1, 200));
    idle_pct = idle_set[3];
    random_items(180);
    drain();

    // Phase: huge radii so snapped points can saturate; mix idle and bursts.
    write_reg(CFG_INNER_RADIUS, 31'h4000_0000 + $urandom_range(0, 1 << 20));
    write_reg(CFG_OUTER_RADIUS, 31'h7FFF_FFFF);
    write_reg(CFG_MATCH_TOLERANCE, $urandom_range(1, 1000));
    idle_pct = idle_set[4];
    corners();
    random_items(80);
    idle_pct = 0;
    random_items(80);
    drain();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
